// ----- hdl/bmnc_pkg.sv -----
// ----------------------------------------------------------------------------
// bmnc_pkg
// Types, constants and class codes shared by the magic-number classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bmnc_pkg;

    localparam int HEAD_BYTES = 1024;
    localparam int HEAD_KEEP  = 12;
    localparam int COUNT_CAP  = (HEAD_BYTES > 2047) ? HEAD_BYTES : 2047;
    localparam int COUNT_W    = $clog2(COUNT_CAP + 1);
    localparam int TAG_LEN    = 9;

    localparam logic [4:0] CLS_UNKNOWN    = 5'd0;
    localparam logic [4:0] CLS_TEXT       = 5'd1;
    localparam logic [4:0] CLS_JPEG       = 5'd2;
    localparam logic [4:0] CLS_PJPEG      = 5'd3;
    localparam logic [4:0] CLS_GIF        = 5'd4;
    localparam logic [4:0] CLS_PNG        = 5'd5;
    localparam logic [4:0] CLS_XMS_BMP    = 5'd6;
    localparam logic [4:0] CLS_TIFF       = 5'd7;
    localparam logic [4:0] CLS_MPEG_AUDIO = 5'd8;
    localparam logic [4:0] CLS_MPEG_VIDEO = 5'd9;
    localparam logic [4:0] CLS_OGG        = 5'd10;
    localparam logic [4:0] CLS_NAVI       = 5'd11;
    localparam logic [4:0] CLS_AVI        = 5'd12;
    localparam logic [4:0] CLS_WAV        = 5'd13;
    localparam logic [4:0] CLS_REALAUDIO  = 5'd14;
    localparam logic [4:0] CLS_ASF        = 5'd15;
    localparam logic [4:0] CLS_QUICKTIME  = 5'd16;
    localparam logic [4:0] CLS_FLASH      = 5'd17;
    localparam logic [4:0] CLS_FLV        = 5'd18;
    localparam logic [4:0] CLS_X_FLV      = 5'd19;
    localparam logic [4:0] CLS_X_ICON     = 5'd20;
    localparam logic [4:0] CLS_BMP        = 5'd21;
    localparam logic [4:0] CLS_MS_ICON    = 5'd22;
    localparam logic [4:0] CLS_PDF        = 5'd23;
    localparam logic [4:0] CLS_JAR        = 5'd24;
    localparam logic [4:0] CLS_ZIP        = 5'd25;
    localparam logic [4:0] CLS_JAVA_VM    = 5'd26;
    localparam logic [4:0] CLS_WORD       = 5'd27;
    localparam logic [4:0] CLS_EXCEL      = 5'd28;
    localparam logic [4:0] CLS_POWERPOINT = 5'd29;
    localparam logic [4:0] CLS_LAST       = CLS_POWERPOINT;

    localparam logic [2:0] HINT_PJPEG = 3'd1;
    localparam logic [2:0] HINT_FLV   = 3'd2;
    localparam logic [2:0] HINT_ICON  = 3'd3;
    localparam logic [2:0] HINT_BMP   = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic [2:0] declared_type;
    } in_item_t;

    typedef struct packed {
        logic       is_text;
        logic [4:0] mime_class;
    } out_item_t;

    typedef struct packed {
        logic [HEAD_KEEP-1:0][7:0] head;
        logic                      text;
        logic [2:0]                hint;
        logic                      above_3;
        logic                      above_512;
        logic [7:0]                byte_512;
        logic                      tag_seen;
    } job_t;

    function automatic logic [7:0] tag_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h4D;
            4'd1:    c = 8'h45;
            4'd2:    c = 8'h54;
            4'd3:    c = 8'h41;
            4'd4:    c = 8'h2D;
            4'd5:    c = 8'h49;
            4'd6:    c = 8'h4E;
            4'd7:    c = 8'h46;
            4'd8:    c = 8'h2F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/bmnc_front.sv -----
// ----------------------------------------------------------------------------
// bmnc_front
// Takes payload bytes, tracks the per-payload state and, on the last byte,
// emits one classification job into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bmnc_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bmnc_pkg::in_item_t s_data,
    input  wire logic              q_full,
    output logic                   q_push,
    output bmnc_pkg::job_t         q_job
);

    logic [bmnc_pkg::HEAD_KEEP-1:0][7:0] head_reg, head_next, head_upd;
    logic [bmnc_pkg::COUNT_W-1:0]        count_reg, count_next, count_upd;
    logic [7:0]                          b512_reg, b512_next, b512_upd;
    logic                                text_reg, text_next, text_upd;
    logic [3:0]                          prog_reg, prog_next, prog_upd;
    logic                                seen_reg, seen_next, seen_upd;
    logic                                accept;
    logic [7:0]                          b;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.data_byte;

    always_comb begin
        head_upd = head_reg;
        for (int i = 0; i < bmnc_pkg::HEAD_KEEP; i++) begin
            if (count_reg == bmnc_pkg::COUNT_W'(i)) begin
                head_upd[i] = b;
            end
        end

        b512_upd = (count_reg == bmnc_pkg::COUNT_W'(512)) ? b : b512_reg;

        text_upd = text_reg;
        if (count_reg < bmnc_pkg::COUNT_W'(bmnc_pkg::HEAD_BYTES) && b < 8'h20 &&
            !(b >= 8'h09 && b <= 8'h0D)) begin
            text_upd = 1'b0;
        end

        prog_upd = prog_reg;
        seen_upd = seen_reg;
        if (!seen_reg) begin
            if (b == bmnc_pkg::tag_char(prog_reg)) begin
                if (prog_reg == 4'(bmnc_pkg::TAG_LEN - 1)) begin
                    seen_upd = 1'b1;
                    prog_upd = 4'd0;
                end else begin
                    prog_upd = prog_reg + 4'd1;
                end
            end else begin
                prog_upd = (b == bmnc_pkg::tag_char(4'd0)) ? 4'd1 : 4'd0;
            end
        end

        count_upd = (count_reg < bmnc_pkg::COUNT_W'(bmnc_pkg::COUNT_CAP)) ?
                    count_reg + bmnc_pkg::COUNT_W'(1) : count_reg;
    end

    always_comb begin
        q_job.head      = head_upd;
        q_job.text      = text_upd;
        q_job.hint      = s_data.declared_type;
        q_job.above_3   = count_upd > bmnc_pkg::COUNT_W'(3);
        q_job.above_512 = count_upd > bmnc_pkg::COUNT_W'(512);
        q_job.byte_512  = b512_upd;
        q_job.tag_seen  = seen_upd;
        q_push          = accept && s_data.last_byte;

        head_next  = head_reg;
        count_next = count_reg;
        b512_next  = b512_reg;
        text_next  = text_reg;
        prog_next  = prog_reg;
        seen_next  = seen_reg;
        if (accept) begin
            if (s_data.last_byte) begin
                head_next  = '0;
                count_next = '0;
                b512_next  = '0;
                text_next  = 1'b1;
                prog_next  = '0;
                seen_next  = 1'b0;
            end else begin
                head_next  = head_upd;
                count_next = count_upd;
                b512_next  = b512_upd;
                text_next  = text_upd;
                prog_next  = prog_upd;
                seen_next  = seen_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            b512_reg  <= '0;
            text_reg  <= 1'b1;
            prog_reg  <= '0;
            seen_reg  <= 1'b0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            b512_reg  <= b512_next;
            text_reg  <= text_next;
            prog_reg  <= prog_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bmnc_queue.sv -----
// ----------------------------------------------------------------------------
// bmnc_queue
// Two-entry queue of classification jobs between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module bmnc_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire bmnc_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output bmnc_pkg::job_t      head_job
);

    bmnc_pkg::job_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_job   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bmnc_back.sv -----
// ----------------------------------------------------------------------------
// bmnc_back
// Matches a job against the binary signatures in priority order and holds
// the result in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bmnc_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    input  wire bmnc_pkg::job_t q_job,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output bmnc_pkg::out_item_t m_data
);

    logic                      out_valid_reg, out_valid_next;
    bmnc_pkg::out_item_t       out_reg, out_next;
    logic [4:0]                cls;
    logic [bmnc_pkg::HEAD_KEEP-1:0][7:0] h;
    logic                      qt;

    function automatic logic tag4(input logic [7:0] p0, input logic [7:0] p1,
                                  input logic [7:0] p2, input logic [7:0] p3,
                                  input logic [31:0] tag);
        return {p0, p1, p2, p3} == tag;
    endfunction

    assign h = q_job.head;

    always_comb begin
        qt = tag4(h[4], h[5], h[6], h[7], "free") ||
             tag4(h[4], h[5], h[6], h[7], "mdat") ||
             tag4(h[4], h[5], h[6], h[7], "wide") ||
             tag4(h[4], h[5], h[6], h[7], "pnot") ||
             tag4(h[4], h[5], h[6], h[7], "skip") ||
             tag4(h[4], h[5], h[6], h[7], "moov");
        cls = bmnc_pkg::CLS_UNKNOWN;
        if (q_job.text) begin
            cls = bmnc_pkg::CLS_TEXT;
        end else if (h[0] == 8'hFF && h[1] == 8'hD8 && h[2] == 8'hFF) begin
            cls = (q_job.hint == bmnc_pkg::HINT_PJPEG) ? bmnc_pkg::CLS_PJPEG :
                                                         bmnc_pkg::CLS_JPEG;
        end else if (tag4(h[0], h[1], h[2], h[3], "GIF8")) begin
            cls = bmnc_pkg::CLS_GIF;
        end else if (h[0] == 8'h89 && h[1] == "P" && h[2] == "N" && h[3] == "G") begin
            cls = bmnc_pkg::CLS_PNG;
        end else if (h[0] == "B" && h[1] == "M") begin
            cls = bmnc_pkg::CLS_XMS_BMP;
        end else if (h[0] == "I" && h[1] == "I" && h[2] == 8'd42) begin
            cls = bmnc_pkg::CLS_TIFF;
        end else if (h[0] == 8'hFF && h[1] == 8'hFB) begin
            cls = bmnc_pkg::CLS_MPEG_AUDIO;
        end else if (h[0] == 8'h00 && h[1] == 8'h00 && h[2] == 8'h01 &&
                     h[3][7:4] == 4'hB) begin
            cls = bmnc_pkg::CLS_MPEG_VIDEO;
        end else if (tag4(h[0], h[1], h[2], h[3], "OggS")) begin
            cls = bmnc_pkg::CLS_OGG;
        end else if (tag4(h[0], h[1], h[2], h[3], "RIFF")) begin
            if (h[8] == "A") begin
                cls = (h[9] == "C") ? bmnc_pkg::CLS_NAVI : bmnc_pkg::CLS_AVI;
            end else begin
                cls = bmnc_pkg::CLS_WAV;
            end
        end else if (h[0] == 8'h28 && h[1] == "R" && h[2] == "M" && h[3] == "F") begin
            cls = bmnc_pkg::CLS_REALAUDIO;
        end else if (h[0] == 8'h30 && h[1] == 8'h26 && h[2] == 8'hB2) begin
            cls = bmnc_pkg::CLS_ASF;
        end else if (qt) begin
            cls = bmnc_pkg::CLS_QUICKTIME;
        end else if ((h[0] == 8'h46 || h[0] == 8'h43) && h[1] == 8'h57 &&
                     h[2] == 8'h53) begin
            cls = bmnc_pkg::CLS_FLASH;
        end else if (h[0] == 8'h46 && h[1] == 8'h4C && h[2] == 8'h56) begin
            cls = (q_job.hint == bmnc_pkg::HINT_FLV) ? bmnc_pkg::CLS_FLV :
                                                       bmnc_pkg::CLS_X_FLV;
        end else if (q_job.above_3 && h[0] == 8'h00 && h[1] == 8'h00 &&
                     h[2] < 8'd3 && h[3] == 8'h00) begin
            if (q_job.hint == bmnc_pkg::HINT_ICON) begin
                cls = bmnc_pkg::CLS_X_ICON;
            end else if (q_job.hint == bmnc_pkg::HINT_BMP) begin
                cls = bmnc_pkg::CLS_BMP;
            end else begin
                cls = bmnc_pkg::CLS_MS_ICON;
            end
        end else if (tag4(h[0], h[1], h[2], h[3], "%PDF")) begin
            cls = bmnc_pkg::CLS_PDF;
        end else if (h[0] == "P" && h[1] == "K" && h[2] < 8'd6 && h[3] < 8'd7) begin
            cls = q_job.tag_seen ? bmnc_pkg::CLS_JAR : bmnc_pkg::CLS_ZIP;
        end else if (h[0] == 8'hCA && h[1] == 8'hFE && h[2] == 8'hBA &&
                     h[3] == 8'hBE) begin
            cls = bmnc_pkg::CLS_JAVA_VM;
        end else if (h[0] == 8'hD0 && h[1] == 8'hCF && h[2] == 8'h11 &&
                     h[3] == 8'hE0 && q_job.above_512) begin
            unique case (q_job.byte_512)
                8'hEC:               cls = bmnc_pkg::CLS_WORD;
                8'hFD, 8'h09:        cls = bmnc_pkg::CLS_EXCEL;
                8'h00, 8'h0F, 8'hA0: cls = bmnc_pkg::CLS_POWERPOINT;
                default:             cls = bmnc_pkg::CLS_UNKNOWN;
            endcase
        end
    end

    assign q_pop   = q_valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (q_pop) begin
            out_valid_next      = 1'b1;
            out_next.is_text    = q_job.text;
            out_next.mime_class = cls;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/binary_magic_number_classifier.sv -----
// ----------------------------------------------------------------------------
// binary_magic_number_classifier
// Streams a payload byte by byte and reports text or the first matching
// binary file signature after the last byte arrives.
//
//   Channel  Direction  Handshake          Item
//   s_       in         s_valid/s_ready    one payload byte, last flag, hint
//   m_       out        m_valid/m_ready    one classification per payload
//
// One byte is accepted per cycle while the job queue has room, and the per-byte
// state is registered at the edge that accepts it. The last byte's job passes
// through the queue into the output register, where m_valid rises once it is free.
// A two-entry job queue sits between the byte front end and the signature
// matcher, so s_ready drops only when that queue is full.
// Reset is synchronous and clears all payload state and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_magic_number_classifier (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire bmnc_pkg::in_item_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output bmnc_pkg::out_item_t     m_data
);

    bmnc_pkg::job_t push_job, head_job;
    logic           push, full, pop, head_valid;

    bmnc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (full),
        .q_push  (push),
        .q_job   (push_job)
    );

    bmnc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    bmnc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (head_valid),
        .q_job   (head_job),
        .q_pop   (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- hdl/bmnc_checker.sv -----
// ----------------------------------------------------------------------------
// bmnc_checker
// Port-level checks on the classifier, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module bmnc_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire bmnc_pkg::in_item_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire bmnc_pkg::out_item_t m_data
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_text_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.is_text == (m_data.mime_class == bmnc_pkg::CLS_TEXT)))
        else $error("text flag and class disagree");

    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.mime_class <= bmnc_pkg::CLS_LAST)
        else $error("class code out of range");

    a_no_result_without_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(m_valid) && !$past(s_valid && s_ready && s_data.last_byte)
        && !$past(s_valid, 2) |-> !m_valid)
        else $error("result without a last byte");

endmodule

bind binary_magic_number_classifier bmnc_checker u_bmnc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ----- test/binary_magic_number_classifier_tb.sv -----
// ----------------------------------------------------------------------------
// binary_magic_number_classifier_tb
// Streams whole payloads through the classifier, one byte per item, and
// checks every classification it returns against a cycle-free prediction.
// Payloads are built from every known signature with random filler, broken
// signatures, text, noise and long headers, under changing idle patterns.
// ----------------------------------------------------------------------------
module binary_magic_number_classifier_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        K_NOISE, K_TEXT, K_JPEG, K_GIF, K_PNG, K_MSBMP, K_TIFF, K_MP3, K_MPEG,
        K_OGG, K_RIFF, K_RM, K_ASF, K_MOV, K_SWF, K_FLV, K_ICON, K_PDF, K_ZIP,
        K_JAVA, K_OFFICE
    } sig_kind_t;

    localparam logic [71:0] ARCHIVE_TAG = "META-INF/";
    localparam int ARCHIVE_TAG_LEN = 9;
    localparam int RANDOM_BYTES = 400;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    bmnc_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    bmnc_pkg::out_item_t m_data;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    logic [7:0]                   pay_head [bmnc_pkg::HEAD_KEEP];
    logic [bmnc_pkg::COUNT_W-1:0] pay_count;
    logic [7:0]                   pay_byte_512;
    logic                         pay_text;
    logic [3:0]                   tag_pos;
    logic                         tag_found;
    bmnc_pkg::out_item_t          expected_q [$];

    logic [7:0] payload_q [$];
    logic [2:0] payload_hint;

    int bytes_sent = 0;
    int payloads_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    logic [31:0] classes_seen = '0;

    binary_magic_number_classifier dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic head_has(input int base, input logic [31:0] w);
        return pay_head[base] == w[31:24] && pay_head[base+1] == w[23:16] &&
               pay_head[base+2] == w[15:8] && pay_head[base+3] == w[7:0];
    endfunction

    function automatic logic [4:0] match_signature(input logic [2:0] hint);
        if (pay_head[0] == 8'hFF && pay_head[1] == 8'hD8 && pay_head[2] == 8'hFF)
            return (hint == bmnc_pkg::HINT_PJPEG) ? bmnc_pkg::CLS_PJPEG :
                                                    bmnc_pkg::CLS_JPEG;
        if (head_has(0, "GIF8")) return bmnc_pkg::CLS_GIF;
        if (head_has(0, {8'h89, "PNG"})) return bmnc_pkg::CLS_PNG;
        if (pay_head[0] == "B" && pay_head[1] == "M") return bmnc_pkg::CLS_XMS_BMP;
        if (pay_head[0] == "I" && pay_head[1] == "I" && pay_head[2] == 8'd42)
            return bmnc_pkg::CLS_TIFF;
        if (pay_head[0] == 8'hFF && pay_head[1] == 8'hFB) return bmnc_pkg::CLS_MPEG_AUDIO;
        if (pay_head[0] == 8'h00 && pay_head[1] == 8'h00 && pay_head[2] == 8'h01 &&
            pay_head[3][7:4] == 4'hB)
            return bmnc_pkg::CLS_MPEG_VIDEO;
        if (head_has(0, "OggS")) return bmnc_pkg::CLS_OGG;
        if (head_has(0, "RIFF")) begin
            if (pay_head[8] == "A")
                return (pay_head[9] == "C") ? bmnc_pkg::CLS_NAVI : bmnc_pkg::CLS_AVI;
            return bmnc_pkg::CLS_WAV;
        end
        if (head_has(0, {8'h28, "RMF"})) return bmnc_pkg::CLS_REALAUDIO;
        if (pay_head[0] == 8'h30 && pay_head[1] == 8'h26 && pay_head[2] == 8'hB2)
            return bmnc_pkg::CLS_ASF;
        if (head_has(4, "free") || head_has(4, "mdat") || head_has(4, "wide") ||
            head_has(4, "pnot") || head_has(4, "skip") || head_has(4, "moov"))
            return bmnc_pkg::CLS_QUICKTIME;
        if ((pay_head[0] == 8'h46 || pay_head[0] == 8'h43) && pay_head[1] == 8'h57 &&
            pay_head[2] == 8'h53)
            return bmnc_pkg::CLS_FLASH;
        if (pay_head[0] == 8'h46 && pay_head[1] == 8'h4C && pay_head[2] == 8'h56)
            return (hint == bmnc_pkg::HINT_FLV) ? bmnc_pkg::CLS_FLV : bmnc_pkg::CLS_X_FLV;
        if (pay_count > 3 && pay_head[0] == 8'h00 && pay_head[1] == 8'h00 &&
            pay_head[2] < 8'd3 && pay_head[3] == 8'h00) begin
            if (hint == bmnc_pkg::HINT_ICON) return bmnc_pkg::CLS_X_ICON;
            if (hint == bmnc_pkg::HINT_BMP) return bmnc_pkg::CLS_BMP;
            return bmnc_pkg::CLS_MS_ICON;
        end
        if (head_has(0, "%PDF")) return bmnc_pkg::CLS_PDF;
        if (pay_head[0] == "P" && pay_head[1] == "K" && pay_head[2] < 8'd6 &&
            pay_head[3] < 8'd7)
            return tag_found ? bmnc_pkg::CLS_JAR : bmnc_pkg::CLS_ZIP;
        if (head_has(0, 32'hCAFEBABE)) return bmnc_pkg::CLS_JAVA_VM;
        if (head_has(0, 32'hD0CF11E0) && pay_count > 512) begin
            case (pay_byte_512)
                8'hEC:               return bmnc_pkg::CLS_WORD;
                8'hFD, 8'h09:        return bmnc_pkg::CLS_EXCEL;
                8'h00, 8'h0F, 8'hA0: return bmnc_pkg::CLS_POWERPOINT;
                default:             return bmnc_pkg::CLS_UNKNOWN;
            endcase
        end
        return bmnc_pkg::CLS_UNKNOWN;
    endfunction

    function automatic void clear_payload_state();
        foreach (pay_head[i]) pay_head[i] = 8'h00;
        pay_count = '0;
        pay_byte_512 = 8'h00;
        pay_text = 1'b1;
        tag_pos = '0;
        tag_found = 1'b0;
    endfunction

    function automatic void absorb_byte(input bmnc_pkg::in_item_t it);
        logic [7:0]          b;
        bmnc_pkg::out_item_t res;
        b = it.data_byte;
        if (pay_count < bmnc_pkg::HEAD_KEEP) pay_head[pay_count] = b;
        if (pay_count == 512) pay_byte_512 = b;
        if (pay_count < bmnc_pkg::HEAD_BYTES && b < 8'h20 && !(b >= 8'h09 && b <= 8'h0D))
            pay_text = 1'b0;
        if (!tag_found) begin
            if (b == ARCHIVE_TAG[71 - 8 * int'(tag_pos) -: 8]) begin
                tag_pos = tag_pos + 1'b1;
                if (tag_pos == ARCHIVE_TAG_LEN) begin
                    tag_found = 1'b1;
                    tag_pos = '0;
                end
            end else begin
                tag_pos = (b == "M") ? 4'd1 : 4'd0;
            end
        end
        if (pay_count < bmnc_pkg::COUNT_CAP) pay_count = pay_count + 1'b1;
        if (it.last_byte) begin
            res.is_text = pay_text;
            res.mime_class = pay_text ? bmnc_pkg::CLS_TEXT :
                                        match_signature(it.declared_type);
            expected_q.push_back(res);
            clear_payload_state();
        end
    endfunction

    // Valid and the payload are driven at the rising edge; ready is sampled at
    // the falling edge, where it already holds its value for the next edge.
    task automatic send_byte(input bmnc_pkg::in_item_t it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        absorb_byte(it);
        bytes_sent++;
    endtask

    task automatic send_payload();
        bmnc_pkg::in_item_t it;
        foreach (payload_q[i]) begin
            it.data_byte = payload_q[i];
            it.last_byte = (i == payload_q.size() - 1);
            it.declared_type = it.last_byte ? payload_hint : 3'($urandom_range(7));
            send_byte(it);
        end
        payloads_sent++;
    endtask

    function automatic logic [7:0] filler_byte(input logic textual);
        int r;
        r = $urandom_range(99);
        if (textual) begin
            if (r < 85) return 8'($urandom_range(8'h7E, 8'h20));
            if (r < 95) return 8'($urandom_range(8'h0D, 8'h09));
            return 8'($urandom_range(8'hFF, 8'h80));
        end
        if (r < 40) return 8'($urandom_range(8'h1F));
        return 8'($urandom_range(8'hFF));
    endfunction

    task automatic fill_payload(input int n, input logic textual);
        payload_q.delete();
        repeat (n) payload_q.push_back(filler_byte(textual));
    endtask

    // Overwrites up to four bytes from pos; bytes past the payload end are dropped.
    task automatic put_word(input int pos, input logic [31:0] w, input int n);
        for (int i = 0; i < n; i++)
            if (pos + i < payload_q.size()) payload_q[pos+i] = w[8*(n-i)-1 -: 8];
    endtask

    task automatic insert_text(input int pos, input string s);
        for (int i = 0; i < s.len(); i++) begin
            if (pos + i < payload_q.size()) payload_q[pos+i] = s[i];
            else payload_q.push_back(s[i]);
        end
    endtask

    task automatic make_payload();
        sig_kind_t kind;
        int        n;
        int        r;
        int        pos;
        logic [7:0] code;
        kind = sig_kind_t'($urandom_range(int'(K_OFFICE)));
        r = $urandom_range(99);
        if (r < 80) n = $urandom_range(14, 1);
        else if (r < 97) n = $urandom_range(40, 15);
        else n = $urandom_range(530, 505);
        fill_payload(n, kind == K_TEXT);
        payload_hint = 3'($urandom_range(7));
        case (kind)
            K_JPEG:  put_word(0, {8'hFF, 8'hD8, 8'hFF}, 3);
            K_GIF:   put_word(0, "GIF8", 4);
            K_PNG:   put_word(0, {8'h89, "PNG"}, 4);
            K_MSBMP: put_word(0, "BM", 2);
            K_TIFF:  put_word(0, {"II", 8'd42}, 3);
            K_MP3:   put_word(0, {8'hFF, 8'hFB}, 2);
            K_MPEG: begin
                put_word(0, {8'h00, 8'h00, 8'h01}, 3);
                if ($urandom_range(99) < 85)
                    put_word(3, {4'hB, 4'($urandom_range(15))}, 1);
            end
            K_OGG:   put_word(0, "OggS", 4);
            K_RIFF: begin
                put_word(0, "RIFF", 4);
                if ($urandom_range(1)) put_word(8, "A", 1);
                if ($urandom_range(1)) put_word(9, "C", 1);
            end
            K_RM:    put_word(0, {8'h28, "RMF"}, 4);
            K_ASF:   put_word(0, {8'h30, 8'h26, 8'hB2}, 3);
            K_MOV: begin
                case ($urandom_range(5))
                    0:       put_word(4, "free", 4);
                    1:       put_word(4, "mdat", 4);
                    2:       put_word(4, "wide", 4);
                    3:       put_word(4, "pnot", 4);
                    4:       put_word(4, "skip", 4);
                    default: put_word(4, "moov", 4);
                endcase
            end
            K_SWF:   put_word(0, {$urandom_range(1) ? 8'h46 : 8'h43, 8'h57, 8'h53}, 3);
            K_FLV:   put_word(0, {8'h46, 8'h4C, 8'h56}, 3);
            K_ICON:  put_word(0, {8'h00, 8'h00, 8'($urandom_range(3)), 8'h00}, 4);
            K_PDF:   put_word(0, "%PDF", 4);
            K_ZIP: begin
                put_word(0, {"PK", 8'($urandom_range(6)), 8'($urandom_range(7))}, 4);
                pos = 4 + $urandom_range(3);
                if (pos > payload_q.size()) pos = payload_q.size();
                case ($urandom_range(4))
                    0:       ;
                    1:       insert_text(pos, "META-INF/");
                    2:       insert_text(pos, "MMETA-INF/");
                    3:       insert_text(pos, "META-IN");
                    default: insert_text(pos, "META-INMETA-INF/");
                endcase
            end
            K_JAVA:  put_word(0, 32'hCAFEBABE, 4);
            K_OFFICE: begin
                if ($urandom_range(99) < 60) begin
                    n = $urandom_range(530, 505);
                    while (payload_q.size() < n) payload_q.push_back(filler_byte(1'b0));
                end
                put_word(0, 32'hD0CF11E0, 4);
                case ($urandom_range(6))
                    0:       code = 8'hEC;
                    1:       code = 8'hFD;
                    2:       code = 8'h09;
                    3:       code = 8'h00;
                    4:       code = 8'h0F;
                    5:       code = 8'hA0;
                    default: code = 8'($urandom_range(255));
                endcase
                put_word(512, code, 1);
            end
            default: ;
        endcase
        if (kind != K_NOISE && kind != K_TEXT && $urandom_range(99) < 12)
            put_word($urandom_range(3), $urandom_range(255), 1);
    endtask

    task automatic test_edge_payloads();
        fill_payload(1, 1'b0); put_word(0, 8'h00, 1); payload_hint = 3'd0;
        send_payload();
        fill_payload(1, 1'b0); put_word(0, 8'hFF, 1); payload_hint = 3'd7;
        send_payload();
        fill_payload(4, 1'b0); put_word(0, {8'h09, 8'h0D, 8'h20, 8'h7E}, 4);
        payload_hint = 3'd5;
        send_payload();
        fill_payload(3, 1'b0); put_word(0, {8'h1F, 8'h08, 8'h0E}, 3);
        payload_hint = 3'd6;
        send_payload();
        fill_payload(4, 1'b0); put_word(0, {8'hFF, 8'hD8, 8'hFF, 8'h00}, 4);
        payload_hint = bmnc_pkg::HINT_PJPEG;
        send_payload();
        fill_payload(4, 1'b0); put_word(0, {8'h00, 8'h00, 8'h01, 8'h00}, 4);
        payload_hint = bmnc_pkg::HINT_ICON;
        send_payload();
        fill_payload(3, 1'b0); put_word(0, {8'h00, 8'h00, 8'h02}, 3);
        payload_hint = bmnc_pkg::HINT_BMP;
        send_payload();
    endtask

    task automatic test_length_limits();
        fill_payload(bmnc_pkg::HEAD_BYTES, 1'b1);
        repeat (2) payload_q.push_back(8'($urandom_range(8'h1F)));
        payload_hint = 3'($urandom_range(7));
        send_payload();
        fill_payload(513, 1'b0);
        put_word(0, 32'hD0CF11E0, 4);
        put_word(512, 8'hA0, 1);
        send_payload();
    endtask

    task automatic test_random_payloads();
        int phase_start;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < RANDOM_BYTES / 4) begin
                make_payload();
                send_payload();
            end
        end
    endtask

    always @(negedge aclk) begin : check_results
        bmnc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            classes_seen[m_data.mime_class] = 1'b1;
            if (expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result is_text=%0d class=%0d", $realtime,
                             m_data.is_text, m_data.mime_class);
            end else begin
                want = expected_q.pop_front();
                if (m_data.is_text !== want.is_text ||
                    m_data.mime_class !== want.mime_class) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch expected is_text=%0d class=%0d, ",
                                  "got is_text=%0d class=%0d"},
                                 $realtime, want.is_text, want.mime_class,
                                 m_data.is_text, m_data.mime_class);
                end
            end
        end
    end

    initial begin
        clear_payload_state();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edge_payloads();
        test_length_limits();
        test_random_payloads();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Sent %0d bytes in %0d payloads and checked %0d classifications.",
                 bytes_sent, payloads_sent, results_checked);
        $display("Distinct classes returned: %0d of 30.", $countones(classes_seen));
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("binary_magic_number_classifier verification clean");
        end else begin
            $display("binary_magic_number_classifier verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding.", expected_q.size());
        $display("binary_magic_number_classifier verification failed");
        $finish;
    end

endmodule
